// ----- design/glprs_pkg.sv -----
// shared constants and register codes for the grid low point risk sum unit
`default_nettype none

package glprs_pkg;

  // grid limits
  localparam int MAX_ROW_LENGTH = 128;
  localparam int MAX_ROWS       = 128;

  // field widths
  localparam int HEIGHT_W   = 4;
  localparam int RISK_W     = 18;
  localparam int COUNT_W    = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // derived position and length widths
  localparam int COL_W  = $clog2(MAX_ROW_LENGTH);
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int LEN_W  = $clog2(MAX_ROW_LENGTH + 1);
  localparam int ROWS_W = $clog2(MAX_ROWS + 1);

  // saturation limits of the totals
  localparam logic [RISK_W-1:0]  RISK_MAX  = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // register reset values
  localparam logic [CFG_DATA_W-1:0] ROW_LENGTH_RST = CFG_DATA_W'(100);
  localparam logic [CFG_DATA_W-1:0] ROW_COUNT_RST  = CFG_DATA_W'(100);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_LENGTH = CFG_IDX_W'(0),
    REG_ROW_COUNT  = CFG_IDX_W'(1)
  } cfg_reg_t;

endpackage

`default_nettype wire

// ----- design/grid_low_point_risk_sum_unit.sv -----
// Latency: the result is shown in the cycle after the frame's final cell is taken.
// Throughput: one cell per cycle; the line buffer read for the next column is issued
// ahead and registered, and the output register lets cells flow on while a
// result waits. The final cell of a frame waits only if an older result is still held.
// Reset: positions, pending flags, neighbor cells and totals clear; row_length and
// row_count return to 100; line buffer contents stay undefined until written.
`default_nettype none

module grid_low_point_risk_sum_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [glprs_pkg::HEIGHT_W-1:0]       in_cell_height,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [glprs_pkg::RISK_W-1:0]         out_risk_total,
  output logic [glprs_pkg::COUNT_W-1:0]        out_low_point_count,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [glprs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [glprs_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import glprs_pkg::*;

  // configuration registers
  logic [CFG_DATA_W-1:0] row_length_r;
  logic [CFG_DATA_W-1:0] row_count_r;

  // frame position and neighbor state
  logic [COL_W-1:0]          col_r, col_nxt;
  logic [ROW_W-1:0]          row_r, row_nxt;
  logic [MAX_ROW_LENGTH-1:0] pend_r, pend_nxt;
  logic [HEIGHT_W-1:0]       left_r, second_left_r, delayed_up_r;
  logic [RISK_W-1:0]         settled_risk_r, settled_risk_nxt;
  logic [RISK_W-1:0]         row_risk_r, row_risk_nxt;
  logic [COUNT_W-1:0]        settled_count_r, settled_count_nxt;
  logic [COUNT_W-1:0]        row_count_acc_r, row_count_acc_nxt;

  // line buffer and its read port
  logic [HEIGHT_W-1:0] line_mem [MAX_ROW_LENGTH];
  logic [HEIGHT_W-1:0] mem_q_r;
  logic                byp_r;
  logic [HEIGHT_W-1:0] byp_data_r;
  logic [COL_W-1:0]    rd_addr;

  // result register
  logic                out_valid_r;
  logic [RISK_W-1:0]   out_risk_r;
  logic [COUNT_W-1:0]  out_count_r;

  // working signals
  logic [LEN_W-1:0]    len_eff;
  logic [ROWS_W-1:0]   rows_eff;
  logic                last_col, last_row, frame_end;
  logic                in_acc;
  logic [HEIGHT_W-1:0] v, u;
  logic                down_hit, cand_l, cand_r;
  logic [RISK_W+1:0]   settled_risk_sum, row_risk_sum;
  logic [RISK_W:0]     out_risk_sum;
  logic [COUNT_W+1:0]  settled_count_sum, row_count_sum;
  logic [COUNT_W:0]    out_count_sum;
  logic [RISK_W-1:0]   row_risk_base;
  logic [COUNT_W-1:0]  row_count_base;

  // effective lengths: zero counts as one, large values clamp to the maximum
  always_comb begin
    if (row_length_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (int'(row_length_r) > MAX_ROW_LENGTH) begin
      len_eff = LEN_W'(MAX_ROW_LENGTH);
    end else begin
      len_eff = LEN_W'(row_length_r);
    end
    if (row_count_r == '0) begin
      rows_eff = ROWS_W'(1);
    end else if (int'(row_count_r) > MAX_ROWS) begin
      rows_eff = ROWS_W'(MAX_ROWS);
    end else begin
      rows_eff = ROWS_W'(row_count_r);
    end
  end

  // position decode and handshake
  assign last_col  = ((LEN_W+1)'(col_r) + (LEN_W+1)'(1)) >= (LEN_W+1)'(len_eff);
  assign last_row  = ((ROWS_W+1)'(row_r) + (ROWS_W+1)'(1)) >= (ROWS_W+1)'(rows_eff);
  assign frame_end = last_col && last_row;
  assign in_ready  = !frame_end || !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign v = in_cell_height;
  assign u = byp_r ? byp_data_r : mem_q_r;

  // next positions
  assign col_nxt = last_col ? '0 : col_r + COL_W'(1);
  assign row_nxt = last_row ? '0 : row_r + ROW_W'(1);
  assign rd_addr = in_acc ? col_nxt : col_r;

  // low point tests
  always_comb begin
    down_hit = (row_r != '0) && pend_r[col_r] && (v > u);
    cand_l   = (col_r != '0) &&
               ((col_r == COL_W'(1)) || (second_left_r > left_r)) &&
               ((row_r == '0) || (delayed_up_r > left_r)) &&
               (v > left_r);
    cand_r   = last_col &&
               ((col_r == '0) || (left_r > v)) &&
               ((row_r == '0) || (u > v));
  end

  // pending flag updates
  always_comb begin
    pend_nxt         = pend_r;
    pend_nxt[col_r]  = 1'b0;
    if (col_r != '0) begin
      pend_nxt[col_r - COL_W'(1)] = cand_l;
    end
    if (last_col) begin
      pend_nxt[col_r] = cand_r;
    end
  end

  // saturating totals
  always_comb begin
    settled_risk_sum  = (RISK_W+2)'(settled_risk_r) +
                        (down_hit ? (RISK_W+2)'(u) + (RISK_W+2)'(1) : '0);
    settled_count_sum = (COUNT_W+2)'(settled_count_r) +
                        (down_hit ? (COUNT_W+2)'(1) : '0);
    settled_risk_nxt  = (settled_risk_sum > (RISK_W+2)'(RISK_MAX)) ?
                        RISK_MAX : settled_risk_sum[RISK_W-1:0];
    settled_count_nxt = (settled_count_sum > (COUNT_W+2)'(COUNT_MAX)) ?
                        COUNT_MAX : settled_count_sum[COUNT_W-1:0];

    row_risk_base  = (col_r == '0) ? '0 : row_risk_r;
    row_count_base = (col_r == '0) ? '0 : row_count_acc_r;
    row_risk_sum   = (RISK_W+2)'(row_risk_base) +
                     (cand_l ? (RISK_W+2)'(left_r) + (RISK_W+2)'(1) : '0) +
                     (cand_r ? (RISK_W+2)'(v) + (RISK_W+2)'(1) : '0);
    row_count_sum  = (COUNT_W+2)'(row_count_base) +
                     (cand_l ? (COUNT_W+2)'(1) : '0) +
                     (cand_r ? (COUNT_W+2)'(1) : '0);
    row_risk_nxt      = (row_risk_sum > (RISK_W+2)'(RISK_MAX)) ?
                        RISK_MAX : row_risk_sum[RISK_W-1:0];
    row_count_acc_nxt = (row_count_sum > (COUNT_W+2)'(COUNT_MAX)) ?
                        COUNT_MAX : row_count_sum[COUNT_W-1:0];

    out_risk_sum  = (RISK_W+1)'(settled_risk_nxt) + (RISK_W+1)'(row_risk_nxt);
    out_count_sum = (COUNT_W+1)'(settled_count_nxt) + (COUNT_W+1)'(row_count_acc_nxt);
  end

  // line buffer: write on each item, read ahead for the next column
  always_ff @(posedge clk) begin
    if (in_acc) begin
      line_mem[col_r] <= v;
    end
    mem_q_r    <= line_mem[rd_addr];
    byp_data_r <= v;
  end

  // write-first forwarding when the next read hits the column just written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else begin
      byp_r <= in_acc && (col_nxt == col_r);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= ROW_LENGTH_RST;
      row_count_r  <= ROW_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROW_LENGTH: row_length_r <= cfg_data;
        REG_ROW_COUNT:  row_count_r  <= cfg_data;
        default:        ;
      endcase
    end
  end

  // frame state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r           <= '0;
      row_r           <= '0;
      pend_r          <= '0;
      left_r          <= '0;
      second_left_r   <= '0;
      delayed_up_r    <= '0;
      settled_risk_r  <= '0;
      settled_count_r <= '0;
      row_risk_r      <= '0;
      row_count_acc_r <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      // result valid: set by a frame's final cell, cleared when taken
      if (in_acc && frame_end) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc) begin
        col_r         <= col_nxt;
        pend_r        <= pend_nxt;
        delayed_up_r  <= u;
        second_left_r <= left_r;
        left_r        <= v;
        if (last_col) begin
          row_r <= row_nxt;
        end
        if (frame_end) begin
          settled_risk_r  <= '0;
          settled_count_r <= '0;
          row_risk_r      <= '0;
          row_count_acc_r <= '0;
        end else begin
          settled_risk_r  <= settled_risk_nxt;
          settled_count_r <= settled_count_nxt;
          row_risk_r      <= row_risk_nxt;
          row_count_acc_r <= row_count_acc_nxt;
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_acc && frame_end) begin
      out_risk_r  <= (out_risk_sum > (RISK_W+1)'(RISK_MAX)) ?
                     RISK_MAX : out_risk_sum[RISK_W-1:0];
      out_count_r <= (out_count_sum > (COUNT_W+1)'(COUNT_MAX)) ?
                     COUNT_MAX : out_count_sum[COUNT_W-1:0];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_risk_total      = out_risk_r;
  assign out_low_point_count = out_count_r;

endmodule

`default_nettype wire

// ----- dv/tb_grid_low_point_risk_sum_unit.sv -----
// self-checking testbench for the grid low point risk sum unit
`default_nettype none

module tb_grid_low_point_risk_sum_unit;
  import glprs_pkg::*;

  // index with no register behind it, writes must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);
  localparam int unsigned RANDOM_CELLS = 620;

  typedef struct packed {
    logic [RISK_W-1:0]  risk;
    logic [COUNT_W-1:0] lows;
  } frame_total_t;

  typedef enum int {FILL_ANY, FILL_DIGITS, FILL_TIES, FILL_PITS} fill_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [HEIGHT_W-1:0]   in_cell_height = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [RISK_W-1:0]     out_risk_total;
  logic [COUNT_W-1:0]    out_low_point_count;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  grid_low_point_risk_sum_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cell_height      (in_cell_height),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_risk_total      (out_risk_total),
    .out_low_point_count (out_low_point_count),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #10 clk = ~clk;

  // register shadows
  logic [CFG_DATA_W-1:0] grid_width_reg  = ROW_LENGTH_RST;
  logic [CFG_DATA_W-1:0] grid_height_reg = ROW_COUNT_RST;

  // low point tracker state
  logic [HEIGHT_W-1:0] above_row [MAX_ROW_LENGTH];
  logic                down_open [MAX_ROW_LENGTH];
  int unsigned         col_at;
  int unsigned         row_at;
  logic [HEIGHT_W-1:0] west_h;
  logic [HEIGHT_W-1:0] west2_h;
  logic [HEIGHT_W-1:0] up_of_west;
  int unsigned         sum_settled;
  int unsigned         n_settled;
  int unsigned         sum_row;
  int unsigned         n_row;

  frame_total_t expected_totals [$];
  int unsigned  error_count = 0;
  int unsigned  random_cells = 0;
  bit           calm = 1'b0;
  int unsigned  hold_req = 0;
  int unsigned  hold_left = 0;
  int unsigned  sink_gap = 0;

  // zero counts as one, oversize counts as the maximum
  function automatic int unsigned span(input logic [CFG_DATA_W-1:0] v, input int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : int'(v);
  endfunction

  function automatic int unsigned sat_sum(input int unsigned a, input int unsigned b,
                                          input int unsigned lim);
    return (a + b > lim) ? lim : a + b;
  endfunction

  function automatic int unsigned frame_cells();
    return span(grid_width_reg, MAX_ROW_LENGTH) * span(grid_height_reg, MAX_ROWS);
  endfunction

  function automatic logic [HEIGHT_W-1:0] pick_height(input fill_t mode);
    case (mode)
      FILL_DIGITS: return HEIGHT_W'($urandom_range(0, 9));
      FILL_TIES:   return HEIGHT_W'($urandom_range(0, 1));
      FILL_PITS:   return ($urandom_range(0, 3) == 0) ? HEIGHT_W'($urandom_range(0, 3))
                                                      : HEIGHT_W'($urandom_range(6, 9));
      default:     return HEIGHT_W'($urandom_range(0, 15));
    endcase
  endfunction

  task automatic clear_tracker();
    for (int i = 0; i < MAX_ROW_LENGTH; i++) begin
      above_row[i] = '0;
      down_open[i] = 1'b0;
    end
    col_at = 0;
    row_at = 0;
    west_h = '0;
    west2_h = '0;
    up_of_west = '0;
    sum_settled = 0;
    n_settled = 0;
    sum_row = 0;
    n_row = 0;
  endtask

  task automatic add_row_low(input logic [HEIGHT_W-1:0] h);
    sum_row = sat_sum(sum_row, 1 + h, RISK_MAX);
    n_row = sat_sum(n_row, 1, COUNT_MAX);
  endtask

  // advance the low point tracker by one accepted cell
  task automatic track_cell(input logic [HEIGHT_W-1:0] h);
    int unsigned         len;
    int unsigned         rows;
    int unsigned         c;
    int unsigned         r;
    logic                last_c;
    logic                last_r;
    logic                low;
    logic [HEIGHT_W-1:0] up;
    frame_total_t        t;
    len = span(grid_width_reg, MAX_ROW_LENGTH);
    rows = span(grid_height_reg, MAX_ROWS);
    c = (col_at >= MAX_ROW_LENGTH) ? MAX_ROW_LENGTH - 1 : col_at;
    r = row_at;
    last_c = (c + 1 >= len);
    last_r = (r + 1 >= rows);
    up = above_row[c];
    if (c == 0) begin
      sum_row = 0;
      n_row = 0;
    end
    // down test of the cell above
    if (r > 0 && down_open[c] && h > up) begin
      sum_settled = sat_sum(sum_settled, 1 + up, RISK_MAX);
      n_settled = sat_sum(n_settled, 1, COUNT_MAX);
    end
    down_open[c] = 1'b0;
    // left cell now has its right neighbor
    if (c > 0) begin
      low = (c == 1 || west2_h > west_h) && (r == 0 || up_of_west > west_h) && (h > west_h);
      down_open[c-1] = low;
      if (low) add_row_low(west_h);
    end
    // last column has no right neighbor
    if (last_c) begin
      low = (c == 0 || west_h > h) && (r == 0 || up > h);
      down_open[c] = low;
      if (low) add_row_low(h);
    end
    up_of_west = up;
    west2_h = west_h;
    west_h = h;
    above_row[c] = h;
    if (!last_c) begin
      col_at = c + 1;
    end else begin
      col_at = 0;
      if (!last_r) begin
        row_at = r + 1;
      end else begin
        t.risk = RISK_W'(sat_sum(sum_settled, sum_row, RISK_MAX));
        t.lows = COUNT_W'(sat_sum(n_settled, n_row, COUNT_MAX));
        expected_totals.push_back(t);
        row_at = 0;
        sum_settled = 0;
        n_settled = 0;
        sum_row = 0;
        n_row = 0;
      end
    end
  endtask

  task automatic check_frame_total(input logic [RISK_W-1:0] risk,
                                   input logic [COUNT_W-1:0] lows);
    frame_total_t want;
    if (expected_totals.size() == 0) begin
      $display("%0t unexpected frame total: risk %0d count %0d", $time, risk, lows);
      error_count++;
    end else begin
      want = expected_totals.pop_front();
      if (want.risk !== risk) begin
        $display("%0t risk_total mismatch: expected %0d actual %0d", $time, want.risk, risk);
        error_count++;
      end
      if (want.lows !== lows) begin
        $display("%0t low_point_count mismatch: expected %0d actual %0d",
                 $time, want.lows, lows);
        error_count++;
      end
    end
  endtask

  // result side: check each item, then pick the next ready value
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_frame_total(out_risk_total, out_low_point_count);
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!calm && sink_gap > 0) begin
      sink_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 13);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_ROW_LENGTH) grid_width_reg = val;
    else if (idx == REG_ROW_COUNT) grid_height_reg = val;
  endtask

  task automatic set_grid(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    write_reg(REG_ROW_LENGTH, w);
    write_reg(REG_ROW_COUNT, h);
    cfg_valid <= 1'b0;
  endtask

  // send one item, sometimes with a random gap ahead of it
  task automatic send_cell(input logic [HEIGHT_W-1:0] h);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cell_height <= h;
    do @(posedge clk); while (!in_ready);
    track_cell(h);
  endtask

  task automatic send_frame(input fill_t mode);
    repeat (frame_cells()) send_cell(pick_height(mode));
  endtask

  // wait for every frame total, then let the block settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_totals.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one-cell frames, zero sizes and heights above nine
  task automatic test_single_cell_frames();
    set_grid(1, 1);
    send_cell(0);
    send_cell(15);
    send_cell(9);
    wait_drained();
    set_grid(0, 0);
    send_cell(10);
    send_cell(3);
    wait_drained();
  endtask

  // hand-built grids: a pit, a plateau, and a small grid above nine
  task automatic test_small_grids();
    logic [HEIGHT_W-1:0] pit  [9];
    logic [HEIGHT_W-1:0] flat [9];
    logic [HEIGHT_W-1:0] high [4];
    pit = '{5, 5, 5, 5, 2, 5, 5, 5, 5};
    flat = '{4, 4, 4, 4, 4, 4, 4, 4, 4};
    high = '{12, 10, 15, 11};
    write_reg(REG_SPARE, 8'hff);
    set_grid(3, 3);
    foreach (pit[i]) send_cell(pit[i]);
    foreach (flat[i]) send_cell(flat[i]);
    wait_drained();
    set_grid(2, 2);
    foreach (high[i]) send_cell(high[i]);
    wait_drained();
  endtask

  // widest and tallest grids, sizes past the maximum
  task automatic test_extreme_sizes();
    set_grid(255, 1);
    send_frame(FILL_ANY);
    wait_drained();
    set_grid(128, 2);
    send_frame(FILL_PITS);
    wait_drained();
    set_grid(1, 255);
    send_frame(FILL_DIGITS);
    wait_drained();
  endtask

  // random grids, mostly small, with random content
  task automatic test_random_frames();
    int unsigned w;
    int unsigned h;
    int unsigned frames;
    fill_t       mode;
    while (random_cells < RANDOM_CELLS) begin
      case ($urandom_range(0, 9))
        0:       w = $urandom_range(0, 1) ? 0 : $urandom_range(129, 255);
        1:       w = $urandom_range(9, 40);
        default: w = $urandom_range(1, 8);
      endcase
      if (span(CFG_DATA_W'(w), MAX_ROW_LENGTH) > 40) h = $urandom_range(1, 2);
      else if ($urandom_range(0, 9) == 0) h = $urandom_range(0, 1) ? 0 : $urandom_range(9, 20);
      else h = $urandom_range(1, 8);
      set_grid(CFG_DATA_W'(w), CFG_DATA_W'(h));
      frames = $urandom_range(1, 3);
      repeat (frames) begin
        mode = fill_t'($urandom_range(0, 3));
        send_frame(mode);
        random_cells += frame_cells();
      end
      wait_drained();
    end
  endtask

  // long result stalls while one-cell and then 2x2 frames keep coming
  task automatic test_output_backpressure();
    set_grid(1, 1);
    hold_req = 300;
    repeat (20) send_cell(pick_height(FILL_ANY));
    wait_drained();
    set_grid(2, 2);
    hold_req = 150;
    repeat (6) send_frame(FILL_DIGITS);
    wait_drained();
  endtask

  // sender stops until all totals are back, same grid after the pause
  task automatic test_pause_until_drained();
    set_grid(4, 3);
    send_frame(FILL_PITS);
    wait_drained();
    send_frame(FILL_ANY);
    wait_drained();
  endtask

  // back-to-back frames at full rate, no idling on either side
  task automatic test_full_rate_tail();
    calm = 1'b1;
    set_grid(5, 4);
    repeat (6) send_frame(FILL_DIGITS);
    wait_drained();
  endtask

  initial begin
    clear_tracker();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_cell_frames();
    test_small_grids();
    test_extreme_sizes();
    test_random_frames();
    test_output_backpressure();
    test_pause_until_drained();
    test_full_rate_tail();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
